// ----- hw/rtl/fas_pkg.sv -----
// Package for the truncating single-precision adder/subtractor.
// Holds field widths, the word width, the queue depth and the front-to-back item type.
// No dependencies.
package fas_pkg;

  localparam int WordW = 32;
  localparam int SigW = 24;
  localparam int ExpW = 8;
  localparam int FracW = 23;
  localparam int QueueDepth = 2;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic             bypass;   // result is known without arithmetic
    logic [WordW-1:0] bypass_value;
    logic             sign_x;
    logic             sign_y;
    logic [ExpW-1:0]  exp_big;
    logic [SigW-1:0]  sig_big;    // significand of the larger-exponent operand
    logic [SigW-1:0]  sig_small;  // aligned significand of the other operand
    logic             big_is_x;
  } fas_item_t;

endpackage

// ----- hw/rtl/float32_add_sub_truncating.sv -----
// Truncating single-precision adder/subtractor, stream interface.
// The result beat passes through the front register, the queue and the back
// register in that order before it is shown on the output.
// Throughput: one beat per cycle while m_tready holds high; fully pipelined.
// Reset (rst, synchronous, active high) empties all stages; no state is kept.
// Depends on fas_pkg, fas_front, fas_queue, fas_back.
module float32_add_sub_truncating #(
  parameter int QueueDepth = fas_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: operand_a[31:0], operand_b[63:32].
  input  logic [63:0] s_tdata,
  // Fields: operation (0 add, 1 subtract).
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: result[31:0].
  output logic [31:0] m_tdata
);

  logic               f_valid, f_ready, b_valid, b_ready;
  fas_pkg::fas_item_t f_item, b_item;

  // The front part classifies each beat and aligns operands.
  fas_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .operation(s_tuser), .operand_a(s_tdata[31:0]), .operand_b(s_tdata[63:32]),
    .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
  );

  // The queue lets each side stall independently.
  fas_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  // The back part adds, normalizes and holds the result beat.
  fas_back u_back (
    .clk(clk), .rst(rst),
    .item_valid(b_valid), .item_ready(b_ready), .item(b_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .result(m_tdata)
  );

endmodule

// ----- hw/rtl/fas_front.sv -----
// Front part: takes a beat, applies the subtract, handles the zero and
// cancellation cases and aligns the smaller operand. Depends on fas_pkg.
module fas_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic [fas_pkg::WordW-1:0] operand_a,
  input  logic [fas_pkg::WordW-1:0] operand_b,
  output logic                    item_valid,
  input  logic                    item_ready,
  output fas_pkg::fas_item_t      item
);

  logic [fas_pkg::WordW-1:0] y;
  logic [fas_pkg::ExpW-1:0]  ex, ey;
  logic [fas_pkg::ExpW-1:0]  diff;
  logic [fas_pkg::SigW-1:0]  mx, my, small_sig;
  logic                      x_lt_y;
  fas_pkg::fas_item_t        cls;

  always_comb begin
    y = (operation && operand_b != '0) ? {~operand_b[31], operand_b[30:0]} : operand_b;
    ex = operand_a[30:23];
    ey = y[30:23];
    mx = {1'b1, operand_a[22:0]};
    my = {1'b1, y[22:0]};
    x_lt_y = ex < ey;
    diff = x_lt_y ? (ey - ex) : (ex - ey);
    small_sig = x_lt_y ? mx : my;
    cls.bypass = 1'b0;
    cls.bypass_value = '0;
    if (operand_a == '0) begin
      cls.bypass = 1'b1;
      cls.bypass_value = y;
    end else if (y == '0) begin
      cls.bypass = 1'b1;
      cls.bypass_value = operand_a;
    end else if ((operand_a ^ 32'h8000_0000) == y) begin
      cls.bypass = 1'b1;
      cls.bypass_value = '0;
    end
    cls.sign_x = operand_a[31];
    cls.sign_y = y[31];
    cls.exp_big = x_lt_y ? ey : ex;
    cls.sig_big = x_lt_y ? my : mx;
    // A significand is 24 bits, so any shift of 24 or more clears it.
    cls.sig_small = (diff >= 8'd24) ? '0 : (small_sig >> diff[4:0]);
    cls.big_is_x = ~x_lt_y;
  end

  // Output register with one skid entry.
  logic               full, skid_full;
  fas_pkg::fas_item_t skid;

  assign in_ready = ~skid_full;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      if (!full || item_ready) begin
        if (skid_full) begin
          item <= skid;
          skid_full <= 1'b0;
          full <= 1'b1;
        end else begin
          item <= cls;
          full <= in_valid;
        end
      end else if (in_valid && in_ready) begin
        skid <= cls;
        skid_full <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/fas_queue.sv -----
// Short queue between the front and back parts.
// Depends on fas_pkg for the item type and depth.
module fas_queue #(
  parameter int Depth = fas_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  fas_pkg::fas_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output fas_pkg::fas_item_t rd_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  fas_pkg::fas_item_t     mem [Depth];
  logic [PtrW-1:0]        wr_ptr, rd_ptr;
  logic [$clog2(Depth+1)-1:0] count;
  logic                   push, pop;

  assign wr_ready = count != Depth[$clog2(Depth+1)-1:0];
  assign rd_valid = count != '0;
  assign rd_item = mem[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

endmodule

// ----- hw/rtl/fas_back.sv -----
// Back part: signed add, magnitude, leading-one normalization, packing,
// or the bypass value. Depends on fas_pkg.
module fas_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  fas_pkg::fas_item_t        item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [fas_pkg::WordW-1:0] result
);

  logic [25:0] sx, sy, sum, mag;
  logic        sgn;
  logic [4:0]  pos;
  logic [7:0]  e;
  logic [25:0] norm;
  logic [fas_pkg::WordW-1:0] packed_res;

  always_comb begin
    sx = item.big_is_x ? {2'b0, item.sig_big} : {2'b0, item.sig_small};
    sy = item.big_is_x ? {2'b0, item.sig_small} : {2'b0, item.sig_big};
    if (item.sign_x) sx = -sx;
    if (item.sign_y) sy = -sy;
    sum = sx + sy;
    sgn = sum[25];
    mag = sgn ? -sum : sum;
    // Magnitude is below 2^25; zero keeps position 23.
    pos = 5'd23;
    for (int i = 0; i < 25; i++) begin
      if (mag[i]) pos = 5'(i);
    end
    if (pos == 5'd24) begin
      norm = mag >> 1;
      e = item.exp_big + 8'd1;
    end else begin
      norm = mag << (5'd23 - pos);
      e = item.exp_big - 8'(5'd23 - pos);
    end
    packed_res = item.bypass ? item.bypass_value : {sgn, e, norm[22:0]};
  end

  assign item_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
      result <= packed_res;
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench for the truncating single-precision adder/subtractor.
// Drives operand pairs with random gaps and checks each result beat against
// a bit-level predictor. Depends on float32_add_sub_truncating and fas_pkg.
`timescale 1ns / 100ps

module tb_top;

  // Operation codes carried on tuser.
  typedef enum logic {
    OpAdd = 1'b0,
    OpSub = 1'b1
  } fas_op_e;

  localparam logic [31:0] SignBit = 32'h8000_0000;
  localparam logic [31:0] HiddenBit = 32'h0080_0000;
  localparam logic [31:0] FracMask = 32'h007F_FFFF;
  localparam int NumRandom = 650;
  localparam int IdlePct = 37;

  typedef struct {
    fas_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
    logic        has_expected;
    logic [31:0] expected;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  logic [31:0] sum_queue[$];
  int          mismatches;
  bit          done;
  bit          calm;   // when set, neither side idles

  float32_add_sub_truncating dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),    // Fields from bit 0: operand_a[31:0], operand_b[63:32].
    .s_tuser (s_tuser),    // Fields: operation.
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)     // Fields from bit 0: result[31:0].
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Bit-accurate sum of two patterns; subtract flips b's sign unless b is
  // the all-zero pattern.
  function automatic logic [31:0] float_sum(fas_op_e op, logic [31:0] a,
                                            logic [31:0] b);
    logic [31:0] y, mx, my, total, mag, sgn;
    int ex, ey, e, lead;
    y = (op == OpSub && b != 0) ? (b ^ SignBit) : b;
    if (a == 0) return y;
    if (y == 0) return a;
    if ((a ^ SignBit) == y) return 32'h0;
    ex = int'(a[30:23]);
    ey = int'(y[30:23]);
    mx = (a & FracMask) | HiddenBit;
    my = (y & FracMask) | HiddenBit;
    if (ex < ey) begin
      mx = (ey - ex >= 32) ? 32'h0 : mx >> (ey - ex);
      e = ey;
    end else begin
      my = (ex - ey >= 32) ? 32'h0 : my >> (ex - ey);
      e = ex;
    end
    if (a[31]) mx = -mx;
    if (y[31]) my = -my;
    total = mx + my;
    sgn = total & SignBit;
    mag = sgn != 0 ? -total : total;
    // A zero magnitude keeps the larger exponent.
    lead = 23;
    for (int i = 31; i >= 0; i--) begin
      if (mag[i]) begin
        lead = i;
        break;
      end
    end
    if (lead > 23) begin
      mag = mag >> (lead - 23);
    end else begin
      mag = mag << (23 - lead);
    end
    e = e + lead - 23;
    return sgn | ({24'h0, e[7:0]} << 23) | (mag & FracMask);
  endfunction

  function automatic logic [31:0] random_pattern();
    logic [31:0] v;
    v = $urandom;
    // Often pull the exponent near the bias or to extremes, or make a signed zero.
    case ($urandom_range(0, 5))
      0: v[30:23] = 8'(127 + $urandom_range(0, 6) - 3);
      1: v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: v = $urandom_range(0, 1) ? 32'h0 : SignBit;
      default: ;
    endcase
    return v;
  endfunction

  // Sends one operand pair and queues its expected sum.
  task automatic send_pair(fas_op_e op, logic [31:0] a, logic [31:0] b);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {b, a};
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sum_queue.push_back(float_sum(op, a, b));
  endtask

  // Consumer side: random backpressure and the check of each result beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (sum_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", m_tdata);
        end else begin
          logic [31:0] want;
          want = sum_queue.pop_front();
          if (m_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h, got %h", want, m_tdata);
          end
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  initial begin
    stim_row_t rows[$];
    fas_op_e   op;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    mismatches = 0;
    done = 1'b0;
    calm = 1'b0;
    // Directed rows; the result is typed in where it is obvious.
    rows = '{
      '{OpAdd, 32'h0, 32'h0, 1'b1, 32'h0},
      '{OpSub, 32'h0, 32'h0, 1'b1, 32'h0},
      '{OpAdd, 32'h0, 32'h4040_0000, 1'b1, 32'h4040_0000},
      '{OpSub, 32'h0, 32'h4040_0000, 1'b1, 32'hC040_0000},
      '{OpAdd, 32'h3F80_0000, 32'h0, 1'b1, 32'h3F80_0000},
      '{OpSub, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0},
      '{OpAdd, 32'h3F80_0000, 32'hBF80_0000, 1'b1, 32'h0},
      // Negative zero as an operand, and subtracted from zero.
      '{OpSub, 32'h0, 32'h8000_0000, 1'b1, 32'h0},
      '{OpAdd, 32'h8000_0000, 32'h3F80_0000, 1'b0, 32'h0},
      '{OpSub, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
      '{OpAdd, 32'h3F80_0000, 32'h3F80_0000, 1'b0, 32'h0},
      '{OpSub, 32'h4000_0000, 32'h3F80_0000, 1'b0, 32'h0},
      // Large alignment shifts, at and beyond 32.
      '{OpAdd, 32'h7F00_0000, 32'h3F80_0000, 1'b0, 32'h0},
      '{OpAdd, 32'h1000_0000, 32'h2000_0000, 1'b0, 32'h0},
      // Nearly the same magnitude, different sign bits, but not a negation pair.
      '{OpAdd, 32'h3F80_0001, 32'hBF80_0000, 1'b0, 32'h0},
      // Exponent wrap at the top and bottom.
      '{OpAdd, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{OpAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{OpSub, 32'h0080_0001, 32'h0080_0000, 1'b0, 32'h0},
      '{OpAdd, 32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0},
      '{OpSub, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
      '{OpAdd, 32'h7F80_0000, 32'hFF7F_FFFF, 1'b0, 32'h0}
    };
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      // Rows with a typed-in result are checked against the predictor too;
      // a predictor slip there shows as a mismatch here.
      if (rows[i].has_expected &&
          float_sum(rows[i].op, rows[i].a, rows[i].b) !== rows[i].expected) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: expected %h", i, rows[i].expected);
      end
      send_pair(rows[i].op, rows[i].a, rows[i].b);
    end
    for (int n = 0; n < NumRandom; n++) begin
      logic [31:0] a, b;
      calm = (n >= 250 && n < 350);
      op = $urandom_range(0, 1) ? OpSub : OpAdd;
      a = random_pattern();
      case ($urandom_range(0, 7))
        0: b = a;
        1: b = a ^ SignBit;
        2: b = {a[31:23] ^ 9'($urandom_range(0, 3)), 23'($urandom)};
        default: b = random_pattern();
      endcase
      send_pair(op, a, b);
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    done = 1'b1;
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a stuck handshake.
  initial begin
    #2_000_000;
    if (!done) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/fas_pkg.sv
hw/rtl/fas_front.sv
hw/rtl/fas_queue.sv
hw/rtl/fas_back.sv
hw/rtl/float32_add_sub_truncating.sv
bench/tb_top.sv
